// File: design/las_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED animation sequencer package
// Shared types, codes, reset values and the raised-cosine level table.
// ----------------------------------------------------------------------------
package las_pkg;

  // Opcodes of an input word
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_PULSE = 3'd1;
  localparam logic [2:0] OP_FADE  = 3'd2;
  localparam logic [2:0] OP_BLINK = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  // Animation modes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_PULSE = 2'd1;
  localparam logic [1:0] MODE_FADE  = 2'd2;
  localparam logic [1:0] MODE_BLINK = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_ENABLED     = 3'd0;
  localparam logic [2:0] REG_ACCEPTED    = 3'd1;
  localparam logic [2:0] REG_TOOL        = 3'd2;
  localparam logic [2:0] REG_INTERVAL    = 3'd3;
  localparam logic [2:0] REG_PULSE_LEN   = 3'd4;
  localparam logic [2:0] REG_PULSE_PER   = 3'd5;
  localparam logic [2:0] REG_FADE_LEN    = 3'd6;
  localparam logic [2:0] REG_BLINK_LEN   = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Reset values
  localparam logic [23:0] RST_ACCEPTED  = 24'h00A800;
  localparam logic [23:0] RST_TOOL      = 24'h8C008C;
  localparam logic [15:0] RST_INTERVAL  = 16'd20;
  localparam logic [15:0] RST_PULSE_LEN = 16'd3000;
  localparam logic [15:0] RST_PULSE_PER = 16'd1000;
  localparam logic [15:0] RST_FADE_LEN  = 16'd500;
  localparam logic [15:0] RST_BLINK_LEN = 16'd1000;

  // Blink pattern: blue-ish on for the first part of every cycle
  localparam logic [15:0] BLINK_CYCLE = 16'd210;
  localparam logic [15:0] BLINK_ON    = 16'd80;
  localparam logic [7:0]  BLINK_GREEN = 8'd80;
  localparam logic [7:0]  BLINK_BLUE  = 8'd255;

  // Divider: 24-bit dividend, 16-bit divisor, one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 24;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic        enabled;
    logic [23:0] accepted_color;
    logic [23:0] tool_color;
    logic [15:0] render_interval;
    logic [15:0] pulse_total_len;
    logic [15:0] pulse_period;
    logic [15:0] fade_len;
    logic [15:0] blink_len;
  } las_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // take the input word
    logic start;      // begin an animation
    logic stop_mode;  // drop back to no animation
    logic render;     // record render time and elapsed time
    logic div_start;
    logic lvl_load;
    logic mul_load;
    logic out_load;
    logic out_black;  // load black instead of the animation color
  } las_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic [1:0] mode;
    logic       enabled;
    logic       throttled;
    logic       expired;
    logic       div_busy;
    logic       out_free;
  } las_sts_t;

  // Entries 0..128 of the raised-cosine table; entry k equals entry 256-k
  localparam logic [7:0] WAVE_HALF [129] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
    8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
    8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,
    8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
    8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
    8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
    8'd79,  8'd82,  8'd85,  8'd88,  8'd90,  8'd93,  8'd97,  8'd100,
    8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124,
    8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd155, 8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173,
    8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
    8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
    8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
    8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244,
    8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
    8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
    8'd255
  };

  function automatic logic [7:0] wave_level(input logic [7:0] idx);
    logic [8:0] mirror;
    mirror = 9'd256 - {1'b0, idx};
    if (idx <= 8'd128) begin
      wave_level = WAVE_HALF[idx];
    end else begin
      wave_level = WAVE_HALF[mirror[7:0]];
    end
  endfunction

endpackage

// File: design/las_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED animation sequencer configuration registers
// Register file written one word at a time through a valid/ready port.
// ----------------------------------------------------------------------------
module las_cfg
  import las_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output las_cfg_t              cfg_o
);

  las_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled         <= 1'b0;
      cfg_q.accepted_color  <= RST_ACCEPTED;
      cfg_q.tool_color      <= RST_TOOL;
      cfg_q.render_interval <= RST_INTERVAL;
      cfg_q.pulse_total_len <= RST_PULSE_LEN;
      cfg_q.pulse_period    <= RST_PULSE_PER;
      cfg_q.fade_len        <= RST_FADE_LEN;
      cfg_q.blink_len       <= RST_BLINK_LEN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ENABLED:   cfg_q.enabled         <= cfg_data_i[0];
        REG_ACCEPTED:  cfg_q.accepted_color  <= cfg_data_i;
        REG_TOOL:      cfg_q.tool_color      <= cfg_data_i;
        REG_INTERVAL:  cfg_q.render_interval <= cfg_data_i[15:0];
        REG_PULSE_LEN: cfg_q.pulse_total_len <= cfg_data_i[15:0];
        REG_PULSE_PER: cfg_q.pulse_period    <= cfg_data_i[15:0];
        REG_FADE_LEN:  cfg_q.fade_len        <= cfg_data_i[15:0];
        REG_BLINK_LEN: cfg_q.blink_len       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/las_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED animation sequencer controller
// Sequences decode, division, level lookup, scaling and result hand-off.
// ----------------------------------------------------------------------------
module las_ctrl
  import las_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  las_sts_t sts_i,
  output las_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PREP,
    ST_DIV,
    ST_LVL,
    ST_MUL,
    ST_EMIT_BLACK,
    ST_EMIT_WAVE
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = ST_IDLE;
        case (sts_i.op)
          OP_PULSE, OP_FADE, OP_BLINK: begin
            cmd_o.start = sts_i.enabled;
          end
          OP_STOP: begin
            cmd_o.stop_mode = 1'b1;
            if (sts_i.enabled) state_d = ST_EMIT_BLACK;
          end
          OP_TICK: begin
            if (sts_i.mode != MODE_NONE && !sts_i.throttled) begin
              cmd_o.render = 1'b1;
              if (sts_i.expired) begin
                cmd_o.stop_mode = 1'b1;
                if (sts_i.enabled) state_d = ST_EMIT_BLACK;
              end else if (sts_i.enabled) begin
                state_d = ST_PREP;
              end
            end
          end
          default: ;
        endcase
      end
      ST_PREP: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = (sts_i.mode == MODE_BLINK) ? ST_EMIT_WAVE : ST_LVL;
        end
      end
      ST_LVL: begin
        cmd_o.lvl_load = 1'b1;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_load = 1'b1;
        state_d        = ST_EMIT_WAVE;
      end
      ST_EMIT_BLACK: begin
        cmd_o.out_black = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_EMIT_WAVE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/las_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED animation sequencer datapath
// Animation state, time checks, shared restoring divider, level scaling and
// the output register.
// ----------------------------------------------------------------------------
module las_dp
  import las_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  las_cfg_t    cfg_i,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] now_ms_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  input  las_cmd_t    cmd_i,
  output las_sts_t    sts_o
);

  // floor(x / 255) for x below 255*256
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    div255 = t[15:8];
  endfunction

  logic [2:0]  op_q;
  logic [31:0] now_q;
  logic [1:0]  mode_q;
  logic [31:0] start_q;
  logic [31:0] last_q;
  logic [15:0] elapsed_q;

  logic [31:0] since_render;
  logic [31:0] elapsed_full;
  logic [15:0] len;

  // divider
  logic                 div_busy_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [23:0]          div_quo_q;
  logic [15:0]          div_rem_q;
  logic [15:0]          div_den_q;
  logic [16:0]          div_shift;
  logic [16:0]          div_diff;
  logic [23:0]          div_num;
  logic [15:0]          div_den;
  logic [15:0]          fade_left;

  logic [7:0]  lvl_q;
  logic [15:0] prod_r_q, prod_g_q, prod_b_q;
  logic [23:0] color;

  logic        out_valid_q;
  logic [7:0]  red_q, green_q, blue_q;
  logic        out_free;

  assign since_render = now_q - last_q;
  assign elapsed_full = now_q - start_q;

  always_comb begin
    case (mode_q)
      MODE_PULSE: len = cfg_i.pulse_total_len;
      MODE_FADE:  len = cfg_i.fade_len;
      default:    len = cfg_i.blink_len;
    endcase
  end

  assign out_free = !out_valid_q || !out_stall_i;

  assign sts_o.op        = op_q;
  assign sts_o.mode      = mode_q;
  assign sts_o.enabled   = cfg_i.enabled;
  assign sts_o.throttled = since_render < {16'd0, cfg_i.render_interval};
  assign sts_o.expired   = elapsed_full >= {16'd0, len};
  assign sts_o.div_busy  = div_busy_q;
  assign sts_o.out_free  = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      now_q <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NONE;
      start_q <= '0;
      last_q  <= '0;
    end else begin
      if (cmd_i.start) begin
        mode_q  <= op_q[1:0];
        start_q <= now_q;
        last_q  <= '0;
      end
      if (cmd_i.render) last_q <= now_q;
      if (cmd_i.stop_mode) mode_q <= MODE_NONE;
    end
  end

  // elapsed is known to be below the mode length when a rendered tick goes on to the divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.render) elapsed_q <= elapsed_full[15:0];
  end

  // Pulse divides elapsed*256 by the period: the low quotient byte is the
  // table index. Fade divides 255*(len-elapsed) by len. Blink keeps the
  // remainder of elapsed by the blink cycle.
  assign fade_left = cfg_i.fade_len - elapsed_q;

  always_comb begin
    case (mode_q)
      MODE_PULSE: begin
        div_num = {elapsed_q, 8'd0};
        div_den = (cfg_i.pulse_period == 16'd0) ? 16'd1 : cfg_i.pulse_period;
      end
      MODE_FADE: begin
        div_num = {fade_left, 8'd0} - {8'd0, fade_left};
        div_den = cfg_i.fade_len;
      end
      default: begin
        div_num = {8'd0, elapsed_q};
        div_den = BLINK_CYCLE;
      end
    endcase
  end

  assign div_shift = {div_rem_q, div_quo_q[23]};
  assign div_diff  = div_shift - {1'b0, div_den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= DIV_CNT_W'(DIV_STEPS);
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
      if (div_cnt_q == DIV_CNT_W'(1)) div_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_quo_q <= div_num;
      div_rem_q <= '0;
      div_den_q <= div_den;
    end else if (div_busy_q) begin
      if (!div_diff[16]) begin
        div_rem_q <= div_diff[15:0];
        div_quo_q <= {div_quo_q[22:0], 1'b1};
      end else begin
        div_rem_q <= div_shift[15:0];
        div_quo_q <= {div_quo_q[22:0], 1'b0};
      end
    end
  end

  assign color = (mode_q == MODE_PULSE) ? cfg_i.tool_color : cfg_i.accepted_color;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lvl_load) begin
      lvl_q <= (mode_q == MODE_PULSE) ? wave_level(div_quo_q[7:0]) : div_quo_q[7:0];
    end
    if (cmd_i.mul_load) begin
      prod_r_q <= 16'(color[23:16]) * 16'(lvl_q);
      prod_g_q <= 16'(color[15:8]) * 16'(lvl_q);
      prod_b_q <= 16'(color[7:0]) * 16'(lvl_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_black) begin
        red_q   <= '0;
        green_q <= '0;
        blue_q  <= '0;
      end else if (mode_q == MODE_BLINK) begin
        red_q   <= '0;
        green_q <= (div_rem_q < BLINK_ON) ? BLINK_GREEN : 8'd0;
        blue_q  <= (div_rem_q < BLINK_ON) ? BLINK_BLUE : 8'd0;
      end else begin
        red_q   <= div255(prod_r_q);
        green_q <= div255(prod_g_q);
        blue_q  <= div255(prod_b_q);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

`ifndef SYNTHESIS
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q && div_cnt_q == DIV_CNT_W'(1) |=> !div_busy_q)
    else $error("divider did not finish after its last step");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy_q |-> div_rem_q < div_den_q)
    else $error("divider remainder not below divisor");

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a word still waiting");
`endif

endmodule

// File: design/led_animation_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED animation sequencer
// Renders pulse, fade and blink LED animations from commands and time ticks.
// ----------------------------------------------------------------------------
// Input channel: opcode_i and now_ms_i, taken when in_valid_i is high and
// in_stall_o is low. The block works on one word at a time and raises
// in_stall_o from acceptance until it is done with that word.
// Output channel: red_o, green_o, blue_o, taken when out_valid_o is high and
// out_stall_i is low. Starts, ignored ticks and unused opcodes give no word.
// Configuration: cfg_index_i selects a register, written with cfg_data_i
// when cfg_valid_i and cfg_ready_o are high; cfg_ready_o is always high.
// With the output register free: starts and ignored ticks are captured and
// evaluated; stop and an expiring tick then emit black; a rendered pulse or
// fade tick runs the shared restoring divider (one quotient bit per cycle),
// level lookup, scaling and emit; a blink tick skips lookup and scaling.
// A result waits in the output register while the receiver stalls; the next
// word is still accepted and held until that register frees up.
// Reset clears the animation state and restores all configuration registers to defaults.
// ----------------------------------------------------------------------------
module led_animation_sequencer
  import las_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            opcode_i,
  input  logic [31:0]           now_ms_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  las_cfg_t cfg;
  las_cmd_t cmd;
  las_sts_t sts;

  las_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  las_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  las_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .opcode_i    (opcode_i),
    .now_ms_i    (now_ms_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
